// ===== hdl/positional_list_engine_defines.svh =====
// ----------------------------------------------------------------------------
// positional_list_engine_defines.svh
// Assertion macros shared by the list engine RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PLE_ASSERT_IMPL(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PLE_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hdl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Field widths, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int OP_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int OUT_IDX_W = 6;
    localparam int OUT_CNT_W = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_BACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_REM_AT    = 3'd5;
    localparam logic [OP_W-1:0] OP_SEARCH    = 3'd6;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic               ins;          // open a slot at idx, write value
        logic               rem;          // close the slot at idx
        logic               load_search;  // lane <= data, flag <= match
        logic               load_rem;     // lane <= data, flag <= (pos == idx)
        logic               shift;        // lane moves one cell toward cell 0
        logic [VALUE_W-1:0] value;
    } ple_cell_ctl_t;

endpackage

// ===== hdl/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: entry register plus one stage of the readout lane.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int IDX_W = 6,
    parameter int CNT_W = 7,
    parameter int POS   = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ple_pkg::ple_cell_ctl_t        ctl,
    input  logic [IDX_W-1:0]              idx,
    input  logic [CNT_W-1:0]              count,
    input  logic [ple_pkg::VALUE_W-1:0]   left_data,
    input  logic [ple_pkg::VALUE_W-1:0]   right_data,
    input  logic                          right_flag,
    input  logic [ple_pkg::VALUE_W-1:0]   right_ldata,
    output logic [ple_pkg::VALUE_W-1:0]   data,
    output logic                          flag,
    output logic [ple_pkg::VALUE_W-1:0]   ldata
);
    import ple_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(POS);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(POS);

    logic [VALUE_W-1:0] data_reg, data_next;
    logic [VALUE_W-1:0] ldata_reg, ldata_next;
    logic               flag_reg, flag_next;
    logic               at_idx, above_idx, live;

    assign at_idx    = (MY_IDX == idx);
    assign above_idx = (MY_IDX > idx);
    assign live      = (MY_CNT < count);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (at_idx)
                data_next = ctl.value;
            else if (above_idx)
                data_next = left_data;
        end
        else if (ctl.rem && (at_idx || above_idx))
        begin
            data_next = right_data;
        end
    end

    always_comb
    begin
        flag_next  = flag_reg;
        ldata_next = ldata_reg;
        if (ctl.load_search)
        begin
            flag_next  = live && (data_reg == ctl.value);
            ldata_next = data_reg;
        end
        else if (ctl.load_rem)
        begin
            flag_next  = at_idx;
            ldata_next = data_reg;
        end
        else if (ctl.shift)
        begin
            flag_next  = right_flag;
            ldata_next = right_ldata;
        end
    end

    // entry storage: undefined until written
    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        ldata_reg <= ldata_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flag_reg <= 1'b0;
        else
            flag_reg <= flag_next;
    end

    assign data  = data_reg;
    assign flag  = flag_reg;
    assign ldata = ldata_reg;

endmodule

// ===== hdl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// Insert and clear answer in the cycle after the transaction is taken;
//   remove and search load the readout lane, which moves one cell per cycle
//   toward cell 0, and answer once the entry removed or first matched
//   reaches cell 0, or once every live entry has passed it on a miss.
// Transactions are handled one at a time; the next is taken once the block is
//   back in IDLE and the output register is free or being read. Reset (async,
//   rst_n low) empties the list and the control; entries keep no reset value.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ple_pkg::OP_W-1:0]            op,
    input  logic signed [ple_pkg::VALUE_W-1:0]  value,
    input  logic signed [ple_pkg::POS_W-1:0]    position,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ple_pkg::STATUS_W-1:0]        status,
    output logic signed [ple_pkg::VALUE_W-1:0]  item_value,
    output logic [ple_pkg::OUT_IDX_W-1:0]       item_index,
    output logic [ple_pkg::OUT_CNT_W-1:0]       entry_count
);
    import ple_pkg::*;

    `include "positional_list_engine_defines.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    // IDLE takes transactions; SCAN drains the readout lane for remove/search
    typedef enum logic {S_IDLE, S_SCAN} state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]       scan_lim_reg, scan_lim_next;
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [VALUE_W-1:0]     out_value_reg, out_value_next;
    logic [OUT_IDX_W-1:0]   out_index_reg, out_index_next;
    logic [OUT_CNT_W-1:0]   out_count_reg, out_count_next;
    logic                   load_out;

    logic                   in_acc;
    logic                   full, empty, ins_op, pos_neg;
    logic [POS_W-1:0]       pos_mag, cnt16, cnt16_m1, ins_at16, rem_at16, op_idx16;
    logic [IDX_W-1:0]       op_idx;
    ple_cell_ctl_t          cell_ctl;

    // cell row wiring
    logic [VALUE_W-1:0]     cell_data  [CAPACITY];
    logic                   cell_flag  [CAPACITY];
    logic [VALUE_W-1:0]     cell_ldata [CAPACITY];
    logic [VALUE_W-1:0]     nb_left    [CAPACITY];
    logic [VALUE_W-1:0]     nb_right   [CAPACITY];
    logic                   nb_rflag   [CAPACITY];
    logic [VALUE_W-1:0]     nb_rldata  [CAPACITY];

    // a transaction is taken only in IDLE with room in the output register
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_acc   = in_valid && !in_stall;

    // ---- index decode ------------------------------------------------------
    assign full     = (count_reg >= CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign ins_op   = (op == OP_INS_FRONT) || (op == OP_INS_BACK) || (op == OP_INS_AT);
    assign pos_neg  = position[POS_W-1];
    assign pos_mag  = POS_W'(unsigned'(position));
    assign cnt16    = POS_W'(count_reg);
    assign cnt16_m1 = cnt16 - POS_W'(1);

    // insert at: non-positive goes to front, past the end appends
    assign ins_at16 = (pos_neg || pos_mag == '0) ? '0 :
                      ((pos_mag > cnt16) ? cnt16 : pos_mag);
    // remove at: past the end takes the last entry
    assign rem_at16 = (pos_mag >= cnt16) ? cnt16_m1 : pos_mag;

    always_comb
    begin
        case (op)
            OP_INS_FRONT: op_idx16 = '0;
            OP_INS_BACK:  op_idx16 = cnt16;
            OP_INS_AT:    op_idx16 = ins_at16;
            OP_REM_FRONT: op_idx16 = '0;
            OP_REM_BACK:  op_idx16 = cnt16_m1;
            OP_REM_AT:    op_idx16 = rem_at16;
            default:      op_idx16 = '0;
        endcase
    end

    assign op_idx = IDX_W'(op_idx16);

    // ---- control -----------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_cnt_next   = scan_cnt_reg;
        scan_lim_next   = scan_lim_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_index_next  = out_index_reg;
        load_out        = 1'b0;
        cell_ctl        = '0;
        cell_ctl.value  = value;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (op)
                        OP_INS_FRONT, OP_INS_BACK, OP_INS_AT:
                        begin
                            load_out = 1'b1;
                            if (full)
                            begin
                                out_status_next = ST_FULL;
                                out_value_next  = '0;
                                out_index_next  = '0;
                            end
                            else
                            begin
                                cell_ctl.ins    = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                                out_status_next = ST_DONE;
                                out_value_next  = value;
                                out_index_next  = OUT_IDX_W'(op_idx16);
                            end
                        end
                        OP_REM_FRONT, OP_REM_BACK, OP_REM_AT:
                        begin
                            if (empty || (op == OP_REM_AT && pos_neg))
                            begin
                                load_out        = 1'b1;
                                out_status_next = ST_EMPTY;
                                out_value_next  = '0;
                                out_index_next  = '0;
                            end
                            else
                            begin
                                // row closes the gap while the lane keeps the old entries
                                cell_ctl.rem      = 1'b1;
                                cell_ctl.load_rem = 1'b1;
                                count_next        = count_reg - CNT_W'(1);
                                scan_cnt_next     = '0;
                                scan_lim_next     = count_reg;
                                state_next        = S_SCAN;
                            end
                        end
                        OP_SEARCH:
                        begin
                            cell_ctl.load_search = 1'b1;
                            scan_cnt_next        = '0;
                            scan_lim_next        = count_reg;
                            state_next           = S_SCAN;
                        end
                        default:
                        begin
                            // clear
                            count_next      = '0;
                            load_out        = 1'b1;
                            out_status_next = ST_DONE;
                            out_value_next  = '0;
                            out_index_next  = '0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (cell_flag[0])
                begin
                    load_out        = 1'b1;
                    out_status_next = ST_DONE;
                    out_value_next  = cell_ldata[0];
                    out_index_next  = OUT_IDX_W'(scan_cnt_reg);
                    state_next      = S_IDLE;
                end
                else if (scan_cnt_reg == scan_lim_reg)
                begin
                    // every live entry passed cell 0 without a match
                    load_out        = 1'b1;
                    out_status_next = ST_MISS;
                    out_value_next  = '0;
                    out_index_next  = '0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cell_ctl.shift = 1'b1;
                    scan_cnt_next  = scan_cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        out_count_next = load_out ? OUT_CNT_W'(count_next) : out_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            scan_cnt_reg   <= '0;
            scan_lim_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_DONE;
            out_value_reg  <= '0;
            out_index_reg  <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_cnt_reg   <= scan_cnt_next;
            scan_lim_reg   <= scan_lim_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
            out_index_reg  <= out_index_next;
            out_count_reg  <= out_count_next;
        end
    end

    // ---- cell row: cell g holds entry g; lane data drains toward cell 0 -----
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign nb_left[g] = '0;
        end
        else
        begin : g_inner_l
            assign nb_left[g] = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign nb_right[g]  = '0;
            assign nb_rflag[g]  = 1'b0;
            assign nb_rldata[g] = '0;
        end
        else
        begin : g_inner_r
            assign nb_right[g]  = cell_data[g+1];
            assign nb_rflag[g]  = cell_flag[g+1];
            assign nb_rldata[g] = cell_ldata[g+1];
        end

        ple_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .POS   (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (cell_ctl),
            .idx         (op_idx),
            .count       (count_reg),
            .left_data   (nb_left[g]),
            .right_data  (nb_right[g]),
            .right_flag  (nb_rflag[g]),
            .right_ldata (nb_rldata[g]),
            .data        (cell_data[g]),
            .flag        (cell_flag[g]),
            .ldata       (cell_ldata[g])
        );
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign item_value  = out_value_reg;
    assign item_index  = out_index_reg;
    assign entry_count = out_count_reg;

    // ---- assertions --------------------------------------------------------
    `PLE_ASSERT_IMPL(a_count_cap, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY),
        "entry count above capacity")
    `PLE_ASSERT_IMPL(a_scan_out_free, clk, rst_n, state_reg == S_SCAN, !out_valid_reg,
        "output register busy during lane scan")
    `PLE_ASSERT_IMPL(a_scan_bound, clk, rst_n, state_reg == S_SCAN,
        scan_cnt_reg <= scan_lim_reg, "lane scan ran past the list")
    `PLE_ASSERT_NEXT(a_insert_grows, clk, rst_n, in_acc && ins_op && !full,
        out_valid_reg && count_reg == $past(count_reg) + CNT_W'(1),
        "insert did not add one entry")

endmodule

// ===== tb/list_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_checker
// Watches both channels of the list engine, keeps a shadow copy of the list,
// predicts one answer per accepted transaction and checks answers in order.
// ----------------------------------------------------------------------------
module list_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [ple_pkg::OP_W-1:0]            op,
    input  logic signed [ple_pkg::VALUE_W-1:0]  value,
    input  logic signed [ple_pkg::POS_W-1:0]    position,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [ple_pkg::STATUS_W-1:0]        status,
    input  logic signed [ple_pkg::VALUE_W-1:0]  item_value,
    input  logic [ple_pkg::OUT_IDX_W-1:0]       item_index,
    input  logic [ple_pkg::OUT_CNT_W-1:0]       entry_count,
    output int                                  errors,
    output int                                  pending,
    output int                                  n_checked,
    output int                                  n_full,
    output int                                  n_empty,
    output int                                  n_miss
);
    import ple_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] item_value;
        logic [OUT_IDX_W-1:0]      item_index;
        logic [OUT_CNT_W-1:0]      entry_count;
    } list_answer_t;

    logic signed [VALUE_W-1:0] shadow_list [CAPACITY];
    int                        shadow_len;
    list_answer_t              answers_due [$];

    function automatic list_answer_t insert_entry(int at, logic signed [VALUE_W-1:0] val);
        list_answer_t ans;
        int           i;
        ans = '0;
        if (shadow_len >= CAPACITY) begin
            ans.status = ST_FULL;
            return ans;
        end
        if (at > shadow_len)
            at = shadow_len;
        for (i = shadow_len; i > at; i--)
            shadow_list[i] = shadow_list[i-1];
        shadow_list[at] = val;
        shadow_len++;
        ans.status     = ST_DONE;
        ans.item_value = val;
        ans.item_index = at[OUT_IDX_W-1:0];
        return ans;
    endfunction

    function automatic list_answer_t remove_entry(int at);
        list_answer_t ans;
        int           i;
        ans = '0;
        if (shadow_len == 0) begin
            ans.status = ST_EMPTY;
            return ans;
        end
        if (at >= shadow_len)
            at = shadow_len - 1;
        ans.status     = ST_DONE;
        ans.item_value = shadow_list[at];
        ans.item_index = at[OUT_IDX_W-1:0];
        for (i = at; i + 1 < shadow_len; i++)
            shadow_list[i] = shadow_list[i+1];
        shadow_len--;
        return ans;
    endfunction

    // one operation against the shadow list; count is taken after the update
    function automatic list_answer_t apply_list_op(logic [OP_W-1:0] code,
                                                   logic signed [VALUE_W-1:0] val,
                                                   logic signed [POS_W-1:0] pos);
        list_answer_t ans;
        int           i;
        ans = '0;
        case (code)
            OP_INS_FRONT: ans = insert_entry(0, val);
            OP_INS_BACK:  ans = insert_entry(shadow_len, val);
            OP_INS_AT:    ans = insert_entry((pos <= 0) ? 0 : int'(pos), val);
            OP_REM_FRONT: ans = remove_entry(0);
            OP_REM_BACK:  ans = remove_entry((shadow_len == 0) ? 0 : shadow_len - 1);
            OP_REM_AT:
            begin
                if (shadow_len == 0 || pos < 0)
                    ans.status = ST_EMPTY;
                else
                    ans = remove_entry(int'(pos));
            end
            OP_SEARCH:
            begin
                ans.status = ST_MISS;
                for (i = 0; i < shadow_len; i++) begin
                    if (shadow_list[i] == val) begin
                        ans.status     = ST_DONE;
                        ans.item_value = val;
                        ans.item_index = i[OUT_IDX_W-1:0];
                        break;
                    end
                end
            end
            default: shadow_len = 0;
        endcase
        ans.entry_count = shadow_len[OUT_CNT_W-1:0];
        return ans;
    endfunction

    task automatic flag_mismatch(string field, longint want, longint got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n) begin
        list_answer_t want;
        if (!rst_n) begin
            shadow_len = 0;
            answers_due.delete();
            errors    = 0;
            pending   = 0;
            n_checked = 0;
            n_full    = 0;
            n_empty   = 0;
            n_miss    = 0;
        end
        else begin
            // answer first: it always belongs to an earlier transaction
            if (out_valid && !out_stall) begin
                if (answers_due.size() == 0) begin
                    errors++;
                    $display("%0t: answer with none expected, expected nothing, actual status %0d",
                             $time, status);
                end
                else begin
                    want = answers_due.pop_front();
                    n_checked++;
                    case (want.status)
                        ST_FULL:  n_full++;
                        ST_EMPTY: n_empty++;
                        ST_MISS:  n_miss++;
                        default: ;
                    endcase
                    if (status !== want.status)
                        flag_mismatch("status", want.status, status);
                    if (item_value !== want.item_value)
                        flag_mismatch("item_value", want.item_value, item_value);
                    if (item_index !== want.item_index)
                        flag_mismatch("item_index", want.item_index, item_index);
                    if (entry_count !== want.entry_count)
                        flag_mismatch("entry_count", want.entry_count, entry_count);
                end
            end
            if (in_valid && !in_stall)
                answers_due.push_back(apply_list_op(op, value, position));
            pending = answers_due.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives list operations into the engine under random valid and stall
// pressure; the checker beside the block predicts and compares every answer.
// ----------------------------------------------------------------------------
module tb;
    import ple_pkg::*;

    localparam int CAPACITY = 64;
    // remove and search answer only after the readout lane scan ends
    localparam int TAIL_CYCLES = CAPACITY + 16;
    localparam int PHASE_ITEMS = 500;

    // bias of the operation mix inside one random segment
    typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED} op_mix_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic signed [POS_W-1:0]   position;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] item_value;
    logic [OUT_IDX_W-1:0]      item_index;
    logic [OUT_CNT_W-1:0]      entry_count;

    int errors;
    int pending;
    int n_checked;
    int n_full;
    int n_empty;
    int n_miss;

    // idle rates in percent, changed per phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    positional_list_engine #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .value(value),
        .position(position),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .item_value(item_value),
        .item_index(item_index),
        .entry_count(entry_count)
    );

    list_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .value(value),
        .position(position),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .item_value(item_value),
        .item_index(item_index),
        .entry_count(entry_count),
        .errors(errors),
        .pending(pending),
        .n_checked(n_checked),
        .n_full(n_full),
        .n_empty(n_empty),
        .n_miss(n_miss)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver back-pressure: a fresh coin per cycle, applied on the falling
    // edge so the block sees a settled stall at the next rising edge.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Hard stop. The slowest legal run is roughly 1600 transactions times the
    // worst search latency plus stall waits, well under a fifth of this.
    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    // One transaction: optional idle cycles first, then hold the payload
    // until the block takes it. Valid stays high straight into the next
    // transaction when no idle cycle is drawn.
    task automatic send_txn(logic [OP_W-1:0] code, logic signed [VALUE_W-1:0] val,
                            logic signed [POS_W-1:0] pos);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        value    <= val;
        position <= pos;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Sender pause until every expected answer is back. The first falling
    // edge lets the checker record the transaction just taken.
    task automatic drain_answers();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [OP_W-1:0] pick_op(op_mix_t mix);
        int              ins_pct;
        int              rem_pct;
        int              r;
        logic [OP_W-1:0] code;
        case (mix)
            MIX_GROW:
            begin
                ins_pct = 80;
                rem_pct = 10;
            end
            MIX_SHRINK:
            begin
                ins_pct = 20;
                rem_pct = 65;
            end
            default:
            begin
                ins_pct = 40;
                rem_pct = 35;
            end
        endcase
        r = $urandom_range(99);
        if (r < ins_pct) begin
            case ($urandom_range(2))
                0:       code = OP_INS_FRONT;
                1:       code = OP_INS_BACK;
                default: code = OP_INS_AT;
            endcase
        end
        else if (r < ins_pct + rem_pct) begin
            case ($urandom_range(2))
                0:       code = OP_REM_FRONT;
                1:       code = OP_REM_BACK;
                default: code = OP_REM_AT;
            endcase
        end
        else if (r < 99)
            code = OP_SEARCH;
        else
            code = OP_CLEAR;
        return code;
    endfunction

    // Small pool values repeat often, so searches hit and find duplicates.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return $urandom_range(16) - 8;
        if (r < 55) begin
            case ($urandom_range(3))
                0:       return 32'sh7fff_ffff;
                1:       return 32'sh8000_0000;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // Mostly around the live range of the list, with negatives, the field
    // extremes and the odd fully random pattern.
    function automatic logic signed [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return POS_W'($urandom_range(CAPACITY + 2));
        if (r < 70)
            return POS_W'(-int'($urandom_range(1, 4)));
        if (r < 80) begin
            case ($urandom_range(3))
                0:       return 16'sh7fff;
                1:       return 16'sh8000;
                2:       return POS_W'(CAPACITY - 1);
                default: return POS_W'(CAPACITY);
            endcase
        end
        return POS_W'($urandom);
    endfunction

    // Random segments with a biased mix. Each phase opens with a long grow
    // segment so the list fills up and inserts get refused.
    task automatic run_phase(int n_items);
        int      done_items;
        int      seg_len;
        int      k;
        op_mix_t mix;
        done_items = 0;
        mix        = MIX_GROW;
        seg_len    = CAPACITY + 30;
        while (done_items < n_items) begin
            for (k = 0; k < seg_len && done_items < n_items; k++) begin
                send_txn(pick_op(mix), pick_value(), pick_position());
                done_items++;
            end
            if ($urandom_range(99) < 15)
                drain_answers();
            mix     = op_mix_t'($urandom_range(2));
            seg_len = $urandom_range(20, 120);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        op       = OP_INS_FRONT;
        value    = '0;
        position = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 36;
        recv_stall_pct = 82;

        // directed: empty list corners
        send_txn(OP_REM_FRONT, 0, 16'sd0);
        send_txn(OP_REM_BACK, 0, 16'sd0);
        send_txn(OP_REM_AT, 0, 16'sd0);
        send_txn(OP_SEARCH, 0, 16'sd0);
        // inserts at every place, value extremes, position clamping
        send_txn(OP_INS_FRONT, 32'sh7fff_ffff, 16'sd0);
        send_txn(OP_INS_BACK, 32'sh8000_0000, 16'sd0);
        send_txn(OP_INS_AT, 5, 16'sh8000);
        send_txn(OP_INS_AT, -1, 16'sh7fff);
        send_txn(OP_INS_AT, 7, 16'sd0);
        send_txn(OP_INS_AT, 9, 16'sd2);
        send_txn(OP_INS_AT, 9, 16'sd6);
        // search: first of duplicates, extreme value, miss
        send_txn(OP_SEARCH, 9, 16'sd0);
        send_txn(OP_SEARCH, 32'sh8000_0000, 16'sd0);
        send_txn(OP_SEARCH, 12345, 16'sd0);
        // removes: negative position is a no-op, past the end takes the last
        send_txn(OP_REM_AT, 0, -16'sd1);
        send_txn(OP_REM_AT, 0, 16'sh8000);
        send_txn(OP_REM_AT, 0, 16'sh7fff);
        send_txn(OP_REM_AT, 0, 16'sd1);
        send_txn(OP_REM_FRONT, 0, 16'sd0);
        send_txn(OP_REM_BACK, 0, 16'sd0);
        // clear, then make sure nothing stale is still visible
        send_txn(OP_CLEAR, 0, 16'sd0);
        send_txn(OP_SEARCH, -1, 16'sd0);
        send_txn(OP_REM_BACK, 0, 16'sd0);
        send_txn(OP_CLEAR, 0, 16'sd0);
        drain_answers();

        run_phase(PHASE_ITEMS);
        drain_answers();

        send_idle_pct  = 82;
        recv_stall_pct = 36;
        run_phase(PHASE_ITEMS);
        drain_answers();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_phase(PHASE_ITEMS);

        // let the last answer come home, then watch for stray ones
        drain_answers();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Checked %0d answers over three idle/stall mixes and a directed opener:",
                 n_checked);
        $display("  %0d refused as full, %0d empty or no-op removes, %0d search misses",
                 n_full, n_empty, n_miss);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
